// ===== rtl/psa_pkg.sv =====
// shared types, constants and helpers for the arccos approximation core
package psa_pkg;

   localparam int MAX_TERMS   = 7;
   localparam int X_W         = 17;
   localparam int COEF_W      = 32;
   localparam int IDX_W       = 3;
   localparam int ROOT_W      = 29;
   localparam int RAD_W       = 58;
   localparam int SQRT_STEPS  = 29;
   localparam logic [X_W-1:0] ONE_Q16 = 17'd65536;

   localparam logic [IDX_W-1:0] REG_NUM_TERMS = 3'd0;

   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      logic             valid;
      logic [X_W-1:0]   x;
      logic [2:0]       terms;
      coef_type         acc;
      logic             sat;
   } horner_type;

   typedef struct packed {
      logic              valid;
      coef_type          acc;
      logic              sat;
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } root_type;

   function automatic coef_type sat32(input logic signed [49:0] v, output logic clip);
      clip = 1'b0;
      sat32 = v[31:0];
      if (v > 50'sd2147483647) begin
         clip = 1'b1;
         sat32 = 32'sh7fffffff;
      end else if (v < -50'sd2147483648) begin
         clip = 1'b1;
         sat32 = 32'sh80000000;
      end
   endfunction

endpackage

// ===== rtl/poly_sqrt_acos_approx_core.sv =====
// top level: horner cell chain, square root cell chain and final scaling
// one transfer accepted every cycle; busy is always low; results cannot be stalled
// path: horner cells, square root cells, then operand, product and output registers
// synchronous reset clears valid bits and sets num_terms to 4, coefficients to 0
module poly_sqrt_acos_approx_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [16:0]           req_x_value,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_y_value,
   output logic                  rsp_saturated
);
   import psa_pkg::*;

   logic [2:0] num_terms_ff;
   coef_type   coef_ff [MAX_TERMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= 3'd4;
         for (int i = 0; i < MAX_TERMS; i++) coef_ff[i] <= '0;
      end else if (csr_write) begin
         if (csr_index == REG_NUM_TERMS) begin
            num_terms_ff <= csr_data[2:0];
         end else begin
            coef_ff[csr_index - 3'd1] <= csr_data;
         end
      end
   end

   horner_type hchain [MAX_TERMS];
   horner_type head;

   always_comb begin
      head.valid = start;
      head.x     = (req_x_value > ONE_Q16) ? ONE_Q16 : req_x_value;
      head.terms = (num_terms_ff == 3'd0) ? 3'd1 : num_terms_ff;
      head.acc   = coef_ff[0];
      head.sat   = 1'b0;
   end
   assign hchain[0] = head;

   for (genvar g = 1; g < MAX_TERMS; g++) begin : g_horner
      psa_horner_cell u_cell (
         .clock(clock), .reset(reset), .stage(3'(g)), .coef(coef_ff[g]),
         .in_data(hchain[g-1]), .out_data(hchain[g]));
   end

   root_type schain [SQRT_STEPS+1];
   root_type sqrt_head;
   logic [X_W-1:0] hx;
   always_comb begin
      hx = ONE_Q16 - hchain[MAX_TERMS-1].x;
      sqrt_head.valid = hchain[MAX_TERMS-1].valid;
      sqrt_head.acc   = hchain[MAX_TERMS-1].acc;
      sqrt_head.sat   = hchain[MAX_TERMS-1].sat;
      sqrt_head.rem   = '0;
      sqrt_head.root  = '0;
      sqrt_head.rad   = {1'b0, hx, 40'd0};
   end
   assign schain[0] = sqrt_head;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      psa_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .in_data(schain[g]), .out_data(schain[g+1]));
   end

   logic               m_valid_ff, m2_valid_ff, o_valid_ff;
   coef_type           m_acc_ff;
   logic [ROOT_W-1:0]  m_root_ff;
   logic               m_sat_ff, m2_sat_ff, o_sat_ff;
   logic signed [61:0] prod_ff, prod_in;
   logic signed [49:0] yw;
   coef_type           y_ff, y_in;
   logic               clip;

   assign prod_in = $signed({{30{m_acc_ff[31]}}, m_acc_ff}) * $signed({33'd0, m_root_ff})
                    + 62'sd134217728;

   always_comb begin
      yw   = 50'(prod_ff >>> 28);
      y_in = sat32(yw, clip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff  <= 1'b0;
         m2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         m_valid_ff  <= schain[SQRT_STEPS].valid;
         m2_valid_ff <= m_valid_ff;
         o_valid_ff  <= m2_valid_ff;
      end
      m_acc_ff  <= schain[SQRT_STEPS].acc;
      m_root_ff <= schain[SQRT_STEPS].root;
      m_sat_ff  <= schain[SQRT_STEPS].sat;
      prod_ff   <= prod_in;
      m2_sat_ff <= m_sat_ff;
      y_ff      <= y_in;
      o_sat_ff  <= m2_sat_ff | clip;
   end

   assign busy          = 1'b0;
   assign rsp_valid     = o_valid_ff;
   assign rsp_y_value   = y_ff;
   assign rsp_saturated = o_sat_ff;
endmodule

// ===== rtl/psa_horner_cell.sv =====
// if stage < terms: acc times x, round, add coef, saturate; else pass
module psa_horner_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           stage,
   input  psa_pkg::coef_type    coef,
   input  psa_pkg::horner_type  in_data,
   output psa_pkg::horner_type  out_data
);
   import psa_pkg::*;

   horner_type data_ff, data_in;
   logic signed [49:0] prod;
   logic signed [49:0] sum;
   coef_type           res;
   logic               clip;

   always_comb begin
      data_in = in_data;
      prod    = ($signed({{18{in_data.acc[31]}}, in_data.acc}) *
                 $signed({33'd0, in_data.x}) + 50'sd32768) >>> 16;
      sum     = prod + $signed({{18{coef[31]}}, coef});
      res     = sat32(sum, clip);
      if (stage < in_data.terms) begin
         data_in.acc = res;
         data_in.sat = in_data.sat | clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.x     <= data_in.x;
      data_ff.terms <= data_in.terms;
      data_ff.acc   <= data_in.acc;
      data_ff.sat   <= data_in.sat;
   end

   assign out_data = data_ff;
endmodule

// ===== rtl/psa_sqrt_cell.sv =====
// one digit of the restoring square root of the radicand
module psa_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  psa_pkg::root_type  in_data,
   output psa_pkg::root_type  out_data
);
   import psa_pkg::*;

   root_type          data_ff, data_in;
   logic [RAD_W-1:0]  rem_sh;
   logic [RAD_W-1:0]  trial;

   always_comb begin
      data_in = in_data;
      rem_sh  = {in_data.rem[RAD_W-3:0], in_data.rad[RAD_W-1 -: 2]};
      trial   = {{(RAD_W-ROOT_W-2){1'b0}}, in_data.root, 2'b01};
      data_in.rad = {in_data.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         data_in.rem  = rem_sh - trial;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.acc  <= data_in.acc;
      data_ff.sat  <= data_in.sat;
      data_ff.rem  <= data_in.rem;
      data_ff.root <= data_in.root;
      data_ff.rad  <= data_in.rad;
   end

   assign out_data = data_ff;
endmodule

// ===== tb/tb_top.sv =====
// testbench for the arccos polynomial core: directed table, random phases, self-checking
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import psa_pkg::*;

   localparam logic [IDX_W-1:0] REG_COEF_BASE = 3'd1;
   localparam int LATENCY_WAIT = 50;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 190;

   typedef struct {
      logic signed [31:0] y;
      logic               sat;
   } acos_result_type;

   typedef struct {
      logic [16:0]        x;
      bit                 typed;
      logic signed [31:0] y;
      logic               sat;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [16:0]        req_x_value;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;
   logic               rsp_valid;
   logic signed [31:0] rsp_y_value;
   logic               rsp_saturated;

   acos_result_type expected_results[$];
   int           terms_reg;
   longint       coef_reg[MAX_TERMS];
   int           mismatches;
   int           items_sent;
   int           results_checked;
   int           sat_seen;
   int           cycles;
   int           burst_left;

   poly_sqrt_acos_approx_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_x_value  (req_x_value),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_y_value  (rsp_y_value),
      .rsp_saturated(rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clip32(longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic acos_result_type predict_acos(logic [16:0] xin);
      acos_result_type r;
      longint xv;
      longint acc;
      longint yv;
      longint unsigned root;
      int n;
      logic flag;
      flag = 1'b0;
      xv = longint'(xin);
      if (xv > 65536) xv = 65536;
      n = terms_reg;
      if (n < 1) n = 1;
      if (n > MAX_TERMS) n = MAX_TERMS;
      acc = coef_reg[0];
      for (int i = 1; i < n; i++) begin
         acc = (acc * xv + 64'sd32768) >>> 16;
         acc = clip32(acc + coef_reg[i], flag);
      end
      root = root_floor(longint'(65536 - xv) << 40);
      yv = (acc * longint'(root) + (64'sd1 <<< 27)) >>> 28;
      yv = clip32(yv, flag);
      r.y = yv[31:0];
      r.sat = flag;
      return r;
   endfunction

   task automatic report(string what, longint want, longint got);
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   task automatic wait_idle();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      if (idx == REG_NUM_TERMS) terms_reg = int'(data[2:0]);
      else coef_reg[idx - REG_COEF_BASE] = longint'($signed(data));
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000);
      endcase
   endfunction

   function automatic logic [16:0] pick_x();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return ONE_Q16;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // drives one transfer; start stays high through a burst
   task automatic send_item(logic [16:0] x, bit typed, logic signed [31:0] y, logic sat);
      acos_result_type e;
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      start = 1'b1;
      req_x_value = x;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (typed) begin
         e.y = y;
         e.sat = sat;
      end else begin
         e = predict_acos(x);
      end
      expected_results.push_back(e);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic stop_sending();
      start = 1'b0;
      burst_left = 0;
   endtask

   always @(posedge clock) begin
      acos_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report("result with nothing pending", 0, rsp_y_value);
         end else begin
            e = expected_results.pop_front();
            if (rsp_y_value !== e.y) report("y_value", e.y, rsp_y_value);
            if (rsp_saturated !== e.sat) report("saturated", e.sat, rsp_saturated);
            if (rsp_saturated === 1'b1) sat_seen++;
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type row;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_x_value = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatches = 0;
      items_sent = 0;
      results_checked = 0;
      sat_seen = 0;
      cycles = 0;
      burst_left = 0;
      terms_reg = 4;
      for (int i = 0; i < MAX_TERMS; i++) coef_reg[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero coefficients after reset give zero everywhere
      table_rows = '{
         '{17'd0, 1, 32'sd0, 1'b0}, '{17'd1, 1, 32'sd0, 1'b0},
         '{17'd65535, 1, 32'sd0, 1'b0}, '{17'd65536, 1, 32'sd0, 1'b0},
         '{17'd65537, 1, 32'sd0, 1'b0}, '{17'd131071, 1, 32'sd0, 1'b0},
         '{17'h0aaaa, 1, 32'sd0, 1'b0}, '{17'h15555, 1, 32'sd0, 1'b0}
      };
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_item(row.x, row.typed, row.y, row.sat);
      end
      stop_sending();
      wait_idle();

      // single term, constant 1.0: y is sqrt(1 - x), zero above one
      write_reg(REG_NUM_TERMS, 32'd1);
      write_reg(REG_COEF_BASE, 32'h10000000);
      table_rows = '{
         '{17'd0, 1, 32'sh10000000, 1'b0}, '{17'd65536, 1, 32'sd0, 1'b0},
         '{17'd131071, 1, 32'sd0, 1'b0}, '{17'd16384, 0, 0, 0},
         '{17'd49152, 0, 0, 0}
      };
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_item(row.x, row.typed, row.y, row.sat);
      end
      stop_sending();
      wait_idle();

      // term count zero, then extreme coefficients at full length
      write_reg(REG_NUM_TERMS, 32'd0);
      send_item(17'd0, 0, 0, 0);
      send_item(17'd30000, 0, 0, 0);
      stop_sending();
      wait_idle();
      write_reg(REG_NUM_TERMS, 32'hfffffff7);
      for (int k = 0; k < MAX_TERMS; k++)
         write_reg(REG_COEF_BASE + 3'(k), (k % 2) ? 32'h80000000 : 32'h7fffffff);
      send_item(17'd0, 0, 0, 0);
      send_item(17'd65535, 0, 0, 0);
      send_item(17'd32768, 0, 0, 0);
      send_item(17'd65536, 0, 0, 0);
      stop_sending();
      wait_idle();

      // arccos-like coefficients with four terms
      write_reg(REG_NUM_TERMS, 32'd4);
      write_reg(REG_COEF_BASE + 3'd0, 32'hfecd1c1c);
      write_reg(REG_COEF_BASE + 3'd1, 32'h04c1ad0a);
      write_reg(REG_COEF_BASE + 3'd2, 32'hf3933de8);
      write_reg(REG_COEF_BASE + 3'd3, 32'h1921fb54);
      send_item(17'd0, 0, 0, 0);
      send_item(17'd1, 0, 0, 0);
      send_item(17'd32768, 0, 0, 0);
      send_item(17'd65535, 0, 0, 0);
      stop_sending();

      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         write_reg(REG_NUM_TERMS, (p == 0) ? 32'd7 : $urandom());
         for (int k = 0; k < MAX_TERMS; k++)
            write_reg(REG_COEF_BASE + 3'(k), pick_coef());
         for (int i = 0; i < PHASE_ITEMS; i++) send_item(pick_x(), 0, 0, 0);
         stop_sending();
      end

      while (expected_results.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
      $display("covered %0d transfers, %0d results checked, %0d saturated",
               items_sent, results_checked, sat_seen);
      $display("term counts 0 to 7, extreme and random coefficients, x up to 131071");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
